>>> hdl/llhs_pkg.sv
// Shared constants and types for the LED level and hold sequencer.
package llhs_pkg;

  localparam int LEDS_DEF        = 9;
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int WORD_BITS_DEF   = 16;

  localparam int OPCODE_W = 2;
  localparam int LED_W    = 4;
  localparam int ENTRY_W  = 6;
  localparam int VALUE_W  = 16;
  localparam int LEVEL_W  = 16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_LENGTH = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

endpackage

>>> hdl/led_level_hold_sequencer_top.sv
// LED level and hold sequencer: per-LED pattern tables stepped on each tick.
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/ready   | opcode, led_index, entry_index, entry_value
//  out_    | output    | out_valid/ready  | led_number, duty_level, last_led
//
// A table write, a malformed item or an unknown opcode is handled in ST_IDLE alone.
// A length item passes through ST_STEP, and also ST_RD_LVL and ST_RD_TGT when it loads a pair.
// A tick steps each LED through ST_STEP and ST_EMIT, with ST_RD_LVL and ST_RD_TGT between
// them when it loads a pair, since the one memory read port fetches level and target in turn.
// Reset clears lengths, positions, levels, targets and counts, but not the pattern memory.
// An output stall holds the sequencer; the next item is taken once the last LED is registered.
module led_level_hold_sequencer_top #(
  parameter int LEDS        = llhs_pkg::LEDS_DEF,
  parameter int TABLE_DEPTH = llhs_pkg::TABLE_DEPTH_DEF,
  parameter int WORD_BITS   = llhs_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [llhs_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [llhs_pkg::LED_W-1:0]    in_led_index,
  input  logic [llhs_pkg::ENTRY_W-1:0]  in_entry_index,
  input  logic [llhs_pkg::VALUE_W-1:0]  in_entry_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [llhs_pkg::LED_W-1:0]    out_led_number,
  output logic [llhs_pkg::LEVEL_W-1:0]  out_duty_level,
  output logic                          out_last_led
);
  import llhs_pkg::*;

  localparam int LIW       = (LEDS > 1) ? $clog2(LEDS) : 1;
  localparam int PW        = $clog2(TABLE_DEPTH);
  localparam int LW        = $clog2(TABLE_DEPTH + 1);
  localparam int AW        = LIW + PW;
  localparam int MEM_DEPTH = 1 << AW;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_STEP   = 5'b00010,
    ST_RD_LVL = 5'b00100,
    ST_RD_TGT = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [LIW-1:0]       led_r, led_nxt;
  logic                 load_only_r, load_only_nxt;

  logic [LW-1:0]        len_r [LEDS];
  logic [PW-1:0]        pos_r [LEDS];
  logic [WORD_BITS-1:0] lvl_r [LEDS];
  logic [WORD_BITS-1:0] tgt_r [LEDS];
  logic [WORD_BITS-1:0] cnt_r [LEDS];

  logic [WORD_BITS-1:0] mem [MEM_DEPTH];
  logic [WORD_BITS-1:0] rd_data_r;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic                 wr_en;

  logic                 out_valid_r;
  logic [LED_W-1:0]     out_led_number_r;
  logic [LEVEL_W-1:0]   out_duty_level_r;
  logic                 out_last_led_r;
  logic                 out_free;
  logic                 out_load;

  logic                 in_take;
  opcode_t              in_op;
  logic                 led_ok;
  logic [LW-1:0]        len_checked;

  logic [LW-1:0]        cur_len;
  logic [PW-1:0]        cur_pos;
  logic [WORD_BITS-1:0] cnt_inc;
  logic                 need_load;
  logic                 table_empty;
  logic [LW-1:0]        pos_step;
  logic [PW-1:0]        pos_wrap;
  logic                 is_last;

  assign in_ready = (state_r == ST_IDLE);
  assign in_take  = in_valid && in_ready;
  assign in_op    = opcode_t'(in_opcode);
  assign led_ok   = (32'(in_led_index) < LEDS);

  assign len_checked = (!in_entry_value[0] && (32'(in_entry_value) <= TABLE_DEPTH)) ?
                       LW'(in_entry_value) : '0;

  assign cur_len     = len_r[led_r];
  assign cur_pos     = pos_r[led_r];
  assign cnt_inc     = cnt_r[led_r] + WORD_BITS'(1);
  assign need_load   = load_only_r || (cnt_inc >= tgt_r[led_r]);
  assign table_empty = (cur_len == '0) || ((LW'(cur_pos) + LW'(1)) >= cur_len);
  assign pos_step    = LW'(cur_pos) + LW'(2);
  assign pos_wrap    = (pos_step >= cur_len) ? '0 : PW'(pos_step);
  assign is_last     = (led_r == LIW'(LEDS - 1));

  assign out_free = !out_valid_r || out_ready;
  assign out_load = (state_r == ST_EMIT) && out_free;

  assign wr_en   = in_take && (in_op == OP_WRITE) && led_ok &&
                   (32'(in_entry_index) < TABLE_DEPTH);
  assign wr_addr = {LIW'(in_led_index), PW'(in_entry_index)};
  assign rd_addr = (state_r == ST_RD_LVL) ? {led_r, PW'(LW'(cur_pos) + LW'(1))} :
                                            {led_r, cur_pos};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= WORD_BITS'(in_entry_value);
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    led_nxt       = led_r;
    load_only_nxt = load_only_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          unique case (in_op)
            OP_TICK: begin
              led_nxt       = '0;
              load_only_nxt = 1'b0;
              state_nxt     = ST_STEP;
            end
            OP_LENGTH: begin
              if (led_ok) begin
                led_nxt       = LIW'(in_led_index);
                load_only_nxt = 1'b1;
                state_nxt     = ST_STEP;
              end
            end
            OP_WRITE, OP_NONE: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_STEP: begin
        if (!need_load) begin
          state_nxt = ST_EMIT;
        end else if (table_empty) begin
          state_nxt = load_only_r ? ST_IDLE : ST_EMIT;
        end else begin
          state_nxt = ST_RD_LVL;
        end
      end
      ST_RD_LVL: begin
        state_nxt = ST_RD_TGT;
      end
      ST_RD_TGT: begin
        state_nxt = load_only_r ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            led_nxt   = led_r + LIW'(1);
            state_nxt = ST_STEP;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      led_r       <= '0;
      load_only_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      led_r       <= led_nxt;
      load_only_r <= load_only_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEDS; i++) begin
        len_r[i] <= '0;
        pos_r[i] <= '0;
        lvl_r[i] <= '0;
        tgt_r[i] <= '0;
        cnt_r[i] <= '0;
      end
    end else begin
      if (in_take && (in_op == OP_LENGTH) && led_ok) begin
        len_r[LIW'(in_led_index)] <= len_checked;
        pos_r[LIW'(in_led_index)] <= '0;
      end
      if (state_r == ST_STEP) begin
        if (!need_load) begin
          cnt_r[led_r] <= cnt_inc;
        end else if (table_empty) begin
          pos_r[led_r] <= '0;
          lvl_r[led_r] <= '0;
          tgt_r[led_r] <= '0;
          cnt_r[led_r] <= '0;
        end
      end
      if (state_r == ST_RD_LVL) begin
        lvl_r[led_r] <= rd_data_r;
      end
      if (state_r == ST_RD_TGT) begin
        tgt_r[led_r] <= rd_data_r;
        cnt_r[led_r] <= '0;
        pos_r[led_r] <= pos_wrap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_led_number_r <= LED_W'(led_r);
      out_duty_level_r <= LEVEL_W'(lvl_r[led_r]);
      out_last_led_r   <= is_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_led_number = out_led_number_r;
  assign out_duty_level = out_duty_level_r;
  assign out_last_led   = out_last_led_r;

  property p_tick_starts_at_first_led;
    @(posedge clk) disable iff (!rst_n)
      (in_take && (in_op == OP_TICK)) |=> (state_r == ST_STEP) && (led_r == '0);
  endproperty
  a_tick_starts_at_first_led: assert property (p_tick_starts_at_first_led)
    else $error("A tick did not start its run at the first LED.");

  property p_read_within_length;
    @(posedge clk) disable iff (!rst_n)
      (state_r == ST_RD_LVL) |-> ((LW'(cur_pos) + LW'(1)) < cur_len);
  endproperty
  a_read_within_length: assert property (p_read_within_length)
    else $error("A pair was fetched beyond the table length.");

  property p_length_well_formed;
    @(posedge clk) disable iff (!rst_n)
      (state_r == ST_STEP) |-> !cur_len[0] && (32'(cur_len) <= TABLE_DEPTH);
  endproperty
  a_length_well_formed: assert property (p_length_well_formed)
    else $error("A stored table length is odd or above the table depth.");

  property p_last_marks_final_led;
    @(posedge clk) disable iff (!rst_n)
      out_load |=> (out_last_led_r == (out_led_number_r == LED_W'(LEDS - 1)));
  endproperty
  a_last_marks_final_led: assert property (p_last_marks_final_led)
    else $error("The last item flag does not match the final LED.");

endmodule
